// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");

`endif

// ===== sv/ffra_pkg.sv =====
// types, constants and request codes of the first-fit region allocator
package ffra_pkg;

   localparam int ADDR_BITS  = 48;
   localparam int SIZE_BITS  = ADDR_BITS + 1;
   localparam int REGIONS    = 16;
   localparam int IDX_BITS   = 4;
   localparam int COUNT_BITS = 5;
   localparam int PAGE_BYTES = 4096;
   localparam int TYPE_BITS  = 4;
   localparam int INDEX_BITS = 16;

   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [SIZE_BITS-1:0]  size_type;
   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [TYPE_BITS-1:0]  code_type;

   localparam size_type PAGE_MASK = size_type'(PAGE_BYTES - 1);

   localparam logic [1:0] REQ_ADD   = 2'd0;
   localparam logic [1:0] REQ_CLOSE = 2'd1;
   localparam logic [1:0] REQ_ALLOC = 2'd2;

   localparam logic [1:0] STAT_DONE   = 2'd0;
   localparam logic [1:0] STAT_NO_FIT = 2'd1;
   localparam logic [1:0] STAT_REJECT = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      addr_type   phys_address;
      addr_type   region_length;
      addr_type   request_size;
      code_type   type_code;
      addr_type   requested_virt;
      logic       map_request;
   } req_item_type;

   typedef struct packed {
      logic [1:0]            status;
      addr_type              alloc_phys;
      addr_type              alloc_virt;
      addr_type              alloc_size;
      code_type              alloc_type;
      logic [INDEX_BITS-1:0] alloc_index;
   } rsp_item_type;

   typedef struct packed {
      addr_type base;
      addr_type length;
      code_type rtype;
      size_type used;
   } region_rec_type;

   typedef struct packed {
      logic     fit;
      addr_type phys;
      size_type new_used;
   } fit_result_type;

endpackage

// ===== sv/first_fit_region_allocator_core.sv =====
// first-fit region allocator: request sequencer around the region table memory
//
// Commands enter on req_data and are accepted at a rising edge with start high
// and busy low. Every command gives exactly one result on rsp_data, shown for
// one cycle with rsp_strobe high; the receiver cannot hold results off.
// Add region, close list and undefined codes answer in the cycle after
// acceptance and never raise busy. An allocate walks the region table in
// order, one entry per cycle through the memory's registered read port; a hit
// ends the walk with its allocation and the last entry without a fit with no
// fit; an open or empty list answers no fit in the cycle after acceptance.
// busy is high for the whole walk, so one item is in work at a time.
// csr_write_en writes the free type code; write it only while idle.
// Synchronous reset empties and reopens the list, sets the next allocation
// index to one and clears the free type code; the table contents are not
// cleared, entries are only read once written.
module first_fit_region_allocator_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ffra_pkg::req_item_type req_data,
   input  logic                  csr_write_en,
   input  ffra_pkg::code_type    csr_write_data,
   output logic                  rsp_strobe,
   output ffra_pkg::rsp_item_type rsp_data
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type                          state_ff, state_in;
   ffra_pkg::idx_type                  scan_idx_ff, scan_idx_in;
   ffra_pkg::count_type                count_ff, count_in;
   logic                               closed_ff, closed_in;
   logic [ffra_pkg::INDEX_BITS-1:0]    alloc_cnt_ff, alloc_cnt_in;
   ffra_pkg::code_type                 free_type_ff, free_type_in;
   logic                               rsp_strobe_ff, rsp_strobe_in;
   ffra_pkg::rsp_item_type             rsp_data_ff, rsp_data_in;
   ffra_pkg::size_type                 size_ff, size_in;
   ffra_pkg::addr_type                 virt_ff, virt_in;
   logic                               map_ff, map_in;
   ffra_pkg::code_type                 atype_ff, atype_in;

   logic                               wr_en;
   ffra_pkg::idx_type                  wr_addr;
   ffra_pkg::region_rec_type           wr_data;
   ffra_pkg::idx_type                  rd_addr;
   ffra_pkg::region_rec_type           rd_data;
   ffra_pkg::fit_result_type           fit;
   ffra_pkg::size_type                 rounded;
   logic                               accept;
   logic                               last_entry;

   ffra_region_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ffra_fit_check u_fit (
      .rec       (rd_data),
      .size      (size_ff),
      .free_type (free_type_ff),
      .result    (fit)
   );

   assign accept     = start && (state_ff == ST_IDLE);
   assign rounded    = ({1'b0, req_data.request_size} + ffra_pkg::PAGE_MASK) &
                       ~ffra_pkg::PAGE_MASK;
   assign last_entry = ({1'b0, scan_idx_ff} == (count_ff - 1'b1));
   // entry 0 is fetched while idle so the walk starts right after acceptance
   assign rd_addr    = (state_ff == ST_SCAN) ? scan_idx_ff + 1'b1 : '0;

   always_comb begin
      state_in      = state_ff;
      scan_idx_in   = scan_idx_ff;
      count_in      = count_ff;
      closed_in     = closed_ff;
      alloc_cnt_in  = alloc_cnt_ff;
      free_type_in  = csr_write_en ? csr_write_data : free_type_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = '0;
      size_in       = size_ff;
      virt_in       = virt_ff;
      map_in        = map_ff;
      atype_in      = atype_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[ffra_pkg::IDX_BITS-1:0];
      wr_data       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_strobe_in      = 1'b1;
               rsp_data_in.status = ffra_pkg::STAT_DONE;
               unique case (req_data.req_type)
                  ffra_pkg::REQ_ADD: begin
                     if (closed_ff ||
                         (count_ff >= ffra_pkg::COUNT_BITS'(ffra_pkg::REGIONS))) begin
                        rsp_data_in.status = ffra_pkg::STAT_REJECT;
                     end else begin
                        wr_en          = 1'b1;
                        wr_data.base   = req_data.phys_address;
                        wr_data.length = req_data.region_length;
                        wr_data.rtype  = req_data.type_code;
                        wr_data.used   = '0;
                        count_in       = count_ff + 1'b1;
                     end
                  end
                  ffra_pkg::REQ_CLOSE: begin
                     closed_in = 1'b1;
                  end
                  ffra_pkg::REQ_ALLOC: begin
                     if (!closed_ff || (count_ff == '0)) begin
                        rsp_data_in.status = ffra_pkg::STAT_NO_FIT;
                     end else begin
                        rsp_strobe_in = 1'b0;
                        size_in       = rounded;
                        virt_in       = req_data.requested_virt;
                        map_in        = req_data.map_request;
                        atype_in      = req_data.type_code;
                        scan_idx_in   = '0;
                        state_in      = ST_SCAN;
                     end
                  end
                  default: begin
                     // undefined code, answered as done with no effect
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (fit.fit) begin
               wr_en        = 1'b1;
               wr_addr      = scan_idx_ff;
               wr_data      = rd_data;
               wr_data.used = fit.new_used;
               rsp_strobe_in          = 1'b1;
               rsp_data_in.status     = ffra_pkg::STAT_DONE;
               rsp_data_in.alloc_phys = fit.phys;
               rsp_data_in.alloc_virt = (map_ff && (virt_ff != ffra_pkg::addr_type'(1))) ?
                                        virt_ff : fit.phys;
               rsp_data_in.alloc_size  = size_ff[ffra_pkg::ADDR_BITS-1:0];
               rsp_data_in.alloc_type  = atype_ff;
               rsp_data_in.alloc_index = alloc_cnt_ff;
               alloc_cnt_in = alloc_cnt_ff + 1'b1;
               state_in     = ST_IDLE;
            end else if (last_entry) begin
               rsp_strobe_in      = 1'b1;
               rsp_data_in.status = ffra_pkg::STAT_NO_FIT;
               state_in           = ST_IDLE;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         closed_ff     <= 1'b0;
         alloc_cnt_ff  <= ffra_pkg::INDEX_BITS'(1);
         free_type_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
         rsp_data_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         closed_ff     <= closed_in;
         alloc_cnt_ff  <= alloc_cnt_in;
         free_type_ff  <= free_type_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      size_ff     <= size_in;
      virt_ff     <= virt_in;
      map_ff      <= map_in;
      atype_ff    <= atype_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== sv/ffra_region_ram.sv =====
// region table memory, one write port and one registered read port
module ffra_region_ram (
   input  logic                    clock,
   input  logic                    wr_en,
   input  ffra_pkg::idx_type       wr_addr,
   input  ffra_pkg::region_rec_type wr_data,
   input  ffra_pkg::idx_type       rd_addr,
   output ffra_pkg::region_rec_type rd_data
);

   ffra_pkg::region_rec_type mem [ffra_pkg::REGIONS];
   ffra_pkg::region_rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ffra_fit_check.sv =====
// fit test of one region entry and the address it would hand out
module ffra_fit_check (
   input  ffra_pkg::region_rec_type rec,
   input  ffra_pkg::size_type       size,
   input  ffra_pkg::code_type       free_type,
   output ffra_pkg::fit_result_type result
);

   logic [ffra_pkg::SIZE_BITS:0] end_offset;

   always_comb begin
      end_offset      = {1'b0, rec.used} + {1'b0, size};
      // exact fit is rejected, so the end must stay strictly below the length
      result.fit      = (rec.rtype == free_type) &&
                        (end_offset < {2'b00, rec.length});
      result.phys     = rec.base + rec.used[ffra_pkg::ADDR_BITS-1:0];
      result.new_used = end_offset[ffra_pkg::SIZE_BITS-1:0];
   end

endmodule

// ===== sv/ffra_checker.sv =====
// port-level checker for the first-fit region allocator, bound to the top level
`include "assert_macros.svh"

module ffra_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_strobe,
   input ffra_pkg::rsp_item_type rsp_data
);

   // an accepted item answers at once or holds the block busy
   `ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, rsp_strobe || busy)
   // leaving the busy walk always delivers its result
   `ASSERT_IMPLY(a_walk_ends_with_item, clock, reset, $fell(busy), rsp_strobe)
   // no result is shown while a walk is still running
   `ASSERT_IMPLY(a_quiet_while_busy, clock, reset, busy, !rsp_strobe)
   // failed items carry no allocation record
   `ASSERT_IMPLY(a_fail_fields_zero, clock, reset,
      rsp_strobe && (rsp_data.status != ffra_pkg::STAT_DONE),
      (rsp_data.alloc_phys == '0) && (rsp_data.alloc_index == '0))

endmodule

bind first_fit_region_allocator_core ffra_checker u_ffra_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
